FILE: design/acfr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// acfr_pkg
// Shared types and constants for the AT command frame receiver.
// ----------------------------------------------------------------------------
package acfr_pkg;

	// item operation codes
	typedef enum logic [1:0] {
		OP_BYTE    = 2'd0,
		OP_TICK    = 2'd1,
		OP_RELEASE = 2'd2,
		OP_READ    = 2'd3
	} op_t;

	// fixed field widths
	localparam int ByteW    = 8;
	localparam int ReadIdxW = 6;
	localparam int LenW     = 7;
	localparam int TimeoutW = 16;
	localparam int TicksW   = 17;

	// framing characters
	localparam logic [ByteW-1:0] CH_A  = 8'h41;
	localparam logic [ByteW-1:0] CH_T  = 8'h54;
	localparam logic [ByteW-1:0] CH_CR = 8'h0D;
	localparam logic [ByteW-1:0] CH_LF = 8'h0A;

	// defaults
	localparam int                  LINE_DEPTH_DEF  = 64;
	localparam logic [TimeoutW-1:0] TIMEOUT_RST     = 16'd1000;

	// configuration register map
	localparam int APB_AW = 3;
	localparam int APB_DW = 32;
	localparam logic [APB_AW-1:0] REG_FRAME_TIMEOUT = 3'd0;

	// one input beat
	typedef struct packed {
		op_t                 op;
		logic [ByteW-1:0]    byte_value;
		logic [ReadIdxW-1:0] read_index;
	} item_t;

	// one result beat
	typedef struct packed {
		logic             frame_ready;
		logic [LenW-1:0]  frame_length;
		logic [ByteW-1:0] read_byte;
		logic             frame_dropped;
	} result_t;

endpackage
`default_nettype wire

FILE: design/acfr_cfg_regs.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// acfr_cfg_regs
// APB-style register block holding the frame timeout limit.
// ----------------------------------------------------------------------------
module acfr_cfg_regs (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           psel,
	input  wire logic                           penable,
	input  wire logic                           pwrite,
	input  wire logic [acfr_pkg::APB_AW-1:0]    paddr,
	input  wire logic [acfr_pkg::APB_DW-1:0]    pwdata,
	output logic      [acfr_pkg::APB_DW-1:0]    prdata,
	output logic                                pready,
	output logic      [acfr_pkg::TimeoutW-1:0]  frame_timeout
);

	logic [acfr_pkg::TimeoutW-1:0] timeout_q;
	logic                          wr_hit;

	// write strobe in the access phase
	assign pready = 1'b1;
	assign wr_hit = psel && penable && pwrite && pready
		&& (paddr == acfr_pkg::REG_FRAME_TIMEOUT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= acfr_pkg::TIMEOUT_RST;
		end else if (wr_hit) begin
			timeout_q <= pwdata[acfr_pkg::TimeoutW-1:0];
		end
	end

	// read back
	always_comb begin
		prdata = '0;
		if (paddr == acfr_pkg::REG_FRAME_TIMEOUT) begin
			prdata = acfr_pkg::APB_DW'(timeout_q);
		end
	end

	assign frame_timeout = timeout_q;

endmodule
`default_nettype wire

FILE: design/acfr_line_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// acfr_line_ram
// Line buffer: one write port, one registered read port, write-first bypass.
// ----------------------------------------------------------------------------
module acfr_line_ram #(
	parameter int LINE_DEPTH = acfr_pkg::LINE_DEPTH_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            wr_en,
	input  wire logic [$clog2(LINE_DEPTH)-1:0]   wr_addr,
	input  wire logic [acfr_pkg::ByteW-1:0]      wr_data,
	input  wire logic                            rd_en,
	input  wire logic [$clog2(LINE_DEPTH)-1:0]   rd_addr,
	output logic      [acfr_pkg::ByteW-1:0]      rd_data
);

	logic [acfr_pkg::ByteW-1:0] mem [LINE_DEPTH];
	logic [acfr_pkg::ByteW-1:0] rd_data_q;

	// store
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// registered read, a same-edge write to the address wins
	always_ff @(posedge clk) begin
		if (rd_en) begin
			if (wr_en && (wr_addr == rd_addr)) begin
				rd_data_q <= wr_data;
			end else begin
				rd_data_q <= mem[rd_addr];
			end
		end
	end

	assign rd_data = rd_data_q;

endmodule
`default_nettype wire

FILE: design/acfr_frame_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// acfr_frame_core
// Framing state and the single-pass update applied to one item per cycle while step_en is set.
// ----------------------------------------------------------------------------
module acfr_frame_core #(
	parameter int LINE_DEPTH = acfr_pkg::LINE_DEPTH_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            step_en,
	input  wire acfr_pkg::item_t                 item,
	input  wire logic [acfr_pkg::ByteW-1:0]      rd_data,
	input  wire logic [acfr_pkg::TimeoutW-1:0]   frame_timeout,
	output logic                                 wr_en,
	output logic      [$clog2(LINE_DEPTH)-1:0]   wr_addr,
	output logic      [acfr_pkg::ByteW-1:0]      wr_data,
	output acfr_pkg::result_t                    result
);

	localparam int AW = $clog2(LINE_DEPTH);
	localparam int CW = $clog2(LINE_DEPTH + 1);
	localparam int XW = (CW > acfr_pkg::ReadIdxW) ? CW : acfr_pkg::ReadIdxW;
	localparam logic [CW-1:0] DepthC = CW'(LINE_DEPTH);

	logic [CW-1:0]                 fill_q, fill_n, fill_inc;
	logic                          ready_q, ready_n;
	logic [acfr_pkg::TicksW-1:0]   ticks_q, ticks_n, ticks_inc;
	logic [acfr_pkg::ByteW-1:0]    last_q, last_n;
	logic                          dropped;
	logic                          rd_in_range;

	assign fill_inc  = fill_q + CW'(1);
	assign ticks_inc = ticks_q + acfr_pkg::TicksW'(1);

	// read window check against the current length
	assign rd_in_range = (XW'(item.read_index) < XW'(fill_q))
		&& (XW'(item.read_index) < XW'(DepthC));

	// next state
	always_comb begin
		fill_n  = fill_q;
		ready_n = ready_q;
		ticks_n = ticks_q;
		last_n  = last_q;
		dropped = 1'b0;
		wr_en   = 1'b0;
		wr_addr = AW'(fill_q);
		wr_data = item.byte_value;
		case (item.op)
			acfr_pkg::OP_BYTE: begin
				if (!ready_q) begin
					if (fill_q == '0) begin
						// header byte one
						if (item.byte_value == acfr_pkg::CH_A) begin
							wr_en  = step_en;
							fill_n = fill_inc;
							last_n = item.byte_value;
						end else begin
							fill_n  = '0;
							ticks_n = '0;
						end
					end else if (fill_q == CW'(1)) begin
						// header byte two
						if (item.byte_value == acfr_pkg::CH_T) begin
							wr_en  = step_en;
							fill_n = fill_inc;
							last_n = item.byte_value;
						end else begin
							fill_n  = '0;
							ticks_n = '0;
						end
					end else if (fill_q >= DepthC) begin
						fill_n  = '0;
						ticks_n = '0;
						dropped = 1'b1;
					end else begin
						// body byte, look for cr lf at the tail
						wr_en  = step_en;
						fill_n = fill_inc;
						last_n = item.byte_value;
						if (last_q == acfr_pkg::CH_CR
							&& item.byte_value == acfr_pkg::CH_LF) begin
							ready_n = 1'b1;
							ticks_n = '0;
						end else if (fill_inc >= DepthC) begin
							fill_n  = '0;
							ticks_n = '0;
							dropped = 1'b1;
						end
					end
				end
			end
			acfr_pkg::OP_TICK: begin
				// timeout on a partial frame
				if (fill_q != '0 && !ready_q) begin
					if (ticks_inc > acfr_pkg::TicksW'(frame_timeout)) begin
						fill_n  = '0;
						ticks_n = '0;
						dropped = 1'b1;
					end else begin
						ticks_n = ticks_inc;
					end
				end
			end
			acfr_pkg::OP_RELEASE: begin
				ready_n = 1'b0;
				fill_n  = '0;
				ticks_n = '0;
			end
			acfr_pkg::OP_READ: begin
				fill_n = fill_q;
			end
			default: begin
				fill_n = fill_q;
			end
		endcase
	end

	// result of this item
	always_comb begin
		result.frame_ready   = ready_n;
		result.frame_length  = acfr_pkg::LenW'(fill_n);
		result.frame_dropped = dropped;
		result.read_byte     = '0;
		if (item.op == acfr_pkg::OP_READ && rd_in_range) begin
			result.read_byte = rd_data;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q  <= '0;
			ready_q <= 1'b0;
			ticks_q <= '0;
		end else if (step_en) begin
			fill_q  <= fill_n;
			ready_q <= ready_n;
			ticks_q <= ticks_n;
		end
	end

	// previous stored byte
	always_ff @(posedge clk) begin
		if (step_en) begin
			last_q <= last_n;
		end
	end

endmodule
`default_nettype wire

FILE: design/at_command_frame_receiver_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// at_command_frame_receiver_unit
// Frames AT command lines from UART bytes; ticks, release and byte reads.
// ----------------------------------------------------------------------------
// Input beats (op, byte_value, read_index) arrive on in_valid / in_ready and
// one result beat (frame_ready, frame_length, read_byte, frame_dropped) leaves
// on out_valid / out_ready for every input beat, in order.
// An accepted beat is held in the input register, where the framing state is
// updated and the line buffer is written; as it advances, its result enters
// the output register and out_valid rises. Throughput is one beat per clock
// while out_ready is high: the state update is a single pass from the input
// register to the output register, and the line buffer has one write and one
// registered read port (read address taken at acceptance). When the receiver
// holds out_ready low, the input register still fills, then in_ready drops
// until the output beat is taken.
// Reset clears the framing state and sets frame_timeout to 1000; the line buffer
// is not cleared, only bytes below frame_length are ever returned. frame_timeout
// sits at APB byte address 0; the user must write it only while idle, unenforced.
// ----------------------------------------------------------------------------
module at_command_frame_receiver_unit #(
	parameter int LINE_DEPTH = acfr_pkg::LINE_DEPTH_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	// configuration
	input  wire logic                            psel,
	input  wire logic                            penable,
	input  wire logic                            pwrite,
	input  wire logic [acfr_pkg::APB_AW-1:0]     paddr,
	input  wire logic [acfr_pkg::APB_DW-1:0]     pwdata,
	output logic      [acfr_pkg::APB_DW-1:0]     prdata,
	output logic                                 pready,
	// input channel
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire logic [1:0]                      op,
	input  wire logic [acfr_pkg::ByteW-1:0]      byte_value,
	input  wire logic [acfr_pkg::ReadIdxW-1:0]   read_index,
	// output channel
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output logic                                 frame_ready,
	output logic      [acfr_pkg::LenW-1:0]       frame_length,
	output logic      [acfr_pkg::ByteW-1:0]      read_byte,
	output logic                                 frame_dropped
);

	localparam int AW = $clog2(LINE_DEPTH);

	logic                          valid_s1;
	acfr_pkg::item_t               item_s1;
	logic                          out_valid_q;
	acfr_pkg::result_t             result_q;
	acfr_pkg::result_t             result_c;
	logic                          s1_adv;
	logic                          in_fire;
	logic [acfr_pkg::TimeoutW-1:0] frame_timeout;
	logic                          wr_en;
	logic [AW-1:0]                 wr_addr;
	logic [acfr_pkg::ByteW-1:0]    wr_data;
	logic [acfr_pkg::ByteW-1:0]    rd_data;

	// handshake
	assign s1_adv   = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || s1_adv;
	assign in_fire  = in_valid && in_ready;

	acfr_cfg_regs u_cfg (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.frame_timeout (frame_timeout)
	);

	acfr_line_ram #(
		.LINE_DEPTH (LINE_DEPTH)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (in_fire),
		.rd_addr (AW'(read_index)),
		.rd_data (rd_data)
	);

	acfr_frame_core #(
		.LINE_DEPTH (LINE_DEPTH)
	) u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.step_en       (s1_adv),
		.item          (item_s1),
		.rd_data       (rd_data),
		.frame_timeout (frame_timeout),
		.wr_en         (wr_en),
		.wr_addr       (wr_addr),
		.wr_data       (wr_data),
		.result        (result_c)
	);

	// input register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// input register payload
	always_ff @(posedge clk) begin
		if (in_fire) begin
			item_s1.op         <= acfr_pkg::op_t'(op);
			item_s1.byte_value <= byte_value;
			item_s1.read_index <= read_index;
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (s1_adv) begin
			result_q <= result_c;
		end
	end

	assign out_valid     = out_valid_q;
	assign frame_ready   = result_q.frame_ready;
	assign frame_length  = result_q.frame_length;
	assign read_byte     = result_q.read_byte;
	assign frame_dropped = result_q.frame_dropped;

	// a dropped frame leaves nothing held
	a_drop_clears: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && result_q.frame_dropped
		|-> !result_q.frame_ready && (result_q.frame_length == '0))
		else $error("dropped frame still holds data");

	// a full input register behind a stalled output blocks new beats
	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && out_valid_q && !out_ready |-> !in_ready)
		else $error("input accepted while both stages are stalled");

	// an item leaving the input register shows up at the output
	a_adv_lands: assert property (@(posedge clk) disable iff (!arst_n)
		s1_adv |=> out_valid_q)
		else $error("advanced item lost before the output register");

endmodule
`default_nettype wire
